// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the timing statistics table.
// Clocked property checks with an active-low reset disable; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/ktst_pkg.sv -----
// Package for the keyed timing statistics table: sizes, command codes, cell structs.
// No dependencies.
`timescale 1ns / 1ps

package ktst_pkg;

  localparam int ENTRIES       = 32;
  localparam int HISTORY_DEPTH = 64;
  localparam int KEY_BITS      = 16;

  // transaction field widths
  localparam int CMD_W  = 1;
  localparam int KEY_FW = 16;
  localparam int TIME_W = 32;
  localparam int RDE_W  = 5;
  localparam int AGE_W  = 6;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 48;

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W    = (KEY_BITS < KEY_FW) ? KEY_BITS : KEY_FW;
  localparam int POS_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W    = $clog2(2 * HISTORY_DEPTH) + 1;
  localparam int STAT_W   = CNT_W + TOT_W;
  localparam int SMP_DEPTH = ENTRIES * HISTORY_DEPTH;
  localparam int SMP_AW   = (SMP_DEPTH > 1) ? $clog2(SMP_DEPTH) : 1;

  localparam logic [CMD_W-1:0] CMD_RECORD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

  // broadcast to every cell; only the selected cell acts on upd
  typedef struct packed {
    logic             upd;
    logic             alloc;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              free;
    logic [POS_W-1:0]  pos;
    logic [FILL_W-1:0] fill;
  } cell_stat_t;

endpackage

// ----- design/ktst_in_if.sv -----
// Command channel of the timing statistics table: valid/ready plus command payload.
// Depends on ktst_pkg.
`timescale 1ns / 1ps

interface ktst_in_if;
  import ktst_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_FW-1:0] event_key;
  logic [TIME_W-1:0] sample_time;
  logic [RDE_W-1:0]  read_entry;
  logic [AGE_W-1:0]  read_age;

  modport source (output valid, cmd, event_key, sample_time, read_entry, read_age,
                  input ready);
  modport sink   (input valid, cmd, event_key, sample_time, read_entry, read_age,
                  output ready);
endinterface

// ----- design/ktst_out_if.sv -----
// Result channel of the timing statistics table: valid/ready plus result payload.
// Depends on ktst_pkg.
`timescale 1ns / 1ps

interface ktst_out_if;
  import ktst_pkg::*;

  logic              valid;
  logic              ready;
  logic [RDE_W-1:0]  entry_index;
  logic              was_new;
  logic              table_full;
  logic [CNT_W-1:0]  call_count;
  logic [TOT_W-1:0]  total_time;
  logic [TIME_W-1:0] sample_out;

  modport source (output valid, entry_index, was_new, table_full, call_count,
                  total_time, sample_out, input ready);
  modport sink   (input valid, entry_index, was_new, table_full, call_count,
                  total_time, sample_out, output ready);
endinterface

// ----- design/keyed_timing_stats_table.sv -----
// channel | dir | handshake           | payload
// in_ch   | in  | valid/ready, sink   | cmd, event_key, sample_time, read_entry, read_age
// out_ch  | out | valid/ready, source | entry_index, was_new, table_full, call_count,
//         |     |                     | total_time, sample_out
// A transaction passes through accept, cell lookup with memory reads, then update and
// result load. The next one is accepted right after; the lookup step holds while the
// output register still has an untaken result. Synchronous reset clears the state, the
// output valid, the cell allocation flags and the used count; sample and statistics
// memories need no clearing pass since only written locations are ever returned.
// Depends on ktst_pkg, ktst_in_if, ktst_out_if, ktst_ram, ktst_cell, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_timing_stats_table (
  input logic        clk,
  input logic        rst_n,
  ktst_in_if.sink    in_ch,
  ktst_out_if.source out_ch
);
  import ktst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_CALC} state_t;

  state_t state_r, state_nxt;

  // latched transaction
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] smp_r;
  logic [RDE_W-1:0]  rde_r;
  logic [AGE_W-1:0]  age_r;

  // lookup results
  logic [IDX_W-1:0]  e_r;
  logic              new_r, full_r, rd_ok_r, age_ok_r;
  logic [POS_W-1:0]  pos_r;
  logic [USED_W-1:0] entries_used_r;

  // output register
  logic              out_valid_r;
  logic [RDE_W-1:0]  out_idx_r;
  logic              out_new_r, out_full_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [TOT_W-1:0]  out_tot_r;
  logic [TIME_W-1:0] out_smp_r;

  // cell row
  cell_ctl_t        cell_ctl;
  cell_stat_t       cell_stat [ENTRIES];
  logic [ENTRIES-1:0] cell_valid, cell_prev, hit_vec, free_vec, sel_vec;
  logic [POS_W-1:0]  cell_pos  [ENTRIES];
  logic [FILL_W-1:0] cell_fill [ENTRIES];

  logic [IDX_W-1:0]  hit_idx, free_idx, look_e;
  logic              any_hit, look_new, look_full, rd_ok, age_ok, go_look;
  logic [POS_W-1:0]  pos_sel;
  logic [FILL_W-1:0] fill_sel;
  logic [SUM_W-1:0]  slot_sum;
  logic [POS_W-1:0]  slot;

  // memories
  logic              mem_we;
  logic [STAT_W-1:0] stat_wdata, stat_rdata;
  logic [SMP_AW-1:0] smp_raddr, smp_waddr;
  logic [TIME_W-1:0] smp_rdata;

  logic [CNT_W-1:0]  base_cnt, cnt_nxt;
  logic [TOT_W-1:0]  base_tot, tot_nxt;
  logic [TOT_W:0]    tot_sum;
  logic              is_rec;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_prev[i] = 1'b1;
    end else begin : g_rest
      assign cell_prev[i] = cell_valid[i-1];
    end
    assign sel_vec[i] = (e_r == IDX_W'(i));

    ktst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .sel        (sel_vec[i]),
      .prev_valid (cell_prev[i]),
      .look_key   (key_r),
      .stat       (cell_stat[i])
    );

    assign cell_valid[i] = cell_stat[i].valid;
    assign hit_vec[i]    = cell_stat[i].hit;
    assign free_vec[i]   = cell_stat[i].free;
    assign cell_pos[i]   = cell_stat[i].pos;
    assign cell_fill[i]  = cell_stat[i].fill;
  end

  // keys are unique among taken cells, so the hit vector is one-hot or empty
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | IDX_W'(i);
      if (free_vec[i]) free_idx = free_idx | IDX_W'(i);
    end
  end

  always_comb begin
    any_hit   = |hit_vec;
    look_full = !any_hit && (entries_used_r == USED_W'(ENTRIES));
    look_new  = !any_hit && !look_full;
    look_e    = (cmd_r == CMD_READ) ? IDX_W'(rde_r) : (any_hit ? hit_idx : free_idx);
    rd_ok     = (32'(rde_r) < ENTRIES) && cell_valid[IDX_W'(rde_r)];
    pos_sel   = cell_pos[look_e];
    fill_sel  = cell_fill[look_e];
    age_ok    = 32'(age_r) < 32'(fill_sel);
    // slot of the age-th older sample, wrapped once
    slot_sum  = SUM_W'(pos_sel) + SUM_W'(HISTORY_DEPTH) - SUM_W'(1) - SUM_W'(age_r);
    if (slot_sum >= SUM_W'(HISTORY_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(HISTORY_DEPTH);
    end
    slot      = POS_W'(slot_sum);
    smp_raddr = SMP_AW'(look_e) * SMP_AW'(HISTORY_DEPTH) + SMP_AW'(slot);
  end

  // update step
  always_comb begin
    is_rec     = (cmd_r == CMD_RECORD);
    base_cnt   = new_r ? '0 : stat_rdata[STAT_W-1:TOT_W];
    base_tot   = new_r ? '0 : stat_rdata[TOT_W-1:0];
    cnt_nxt    = (&base_cnt) ? base_cnt : base_cnt + 1'b1;
    tot_sum    = {1'b0, base_tot} + (TOT_W + 1)'(smp_r);
    tot_nxt    = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
    mem_we     = (state_r == S_CALC) && is_rec && !full_r;
    stat_wdata = {cnt_nxt, tot_nxt};
    smp_waddr  = SMP_AW'(e_r) * SMP_AW'(HISTORY_DEPTH) + SMP_AW'(pos_r);
    cell_ctl.upd   = mem_we;
    cell_ctl.alloc = new_r;
    cell_ctl.key   = key_r;
  end

  ktst_ram #(.W(STAT_W), .DEPTH(ENTRIES)) u_stat_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (e_r),
    .wdata (stat_wdata),
    .raddr (look_e),
    .rdata (stat_rdata)
  );

  ktst_ram #(.W(TIME_W), .DEPTH(SMP_DEPTH)) u_smp_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (smp_waddr),
    .wdata (smp_r),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  // lookup may proceed once the output register is free by the next edge
  assign go_look = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_LOOK;
      S_LOOK:  if (go_look) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      entries_used_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r <= in_ch.cmd;
            key_r <= in_ch.event_key[KEY_W-1:0];
            smp_r <= in_ch.sample_time;
            rde_r <= in_ch.read_entry;
            age_r <= in_ch.read_age;
          end
        end
        S_LOOK: begin
          e_r      <= look_e;
          new_r    <= look_new;
          full_r   <= look_full;
          rd_ok_r  <= rd_ok;
          age_ok_r <= age_ok;
          // a fresh entry starts its ring at slot 0
          pos_r    <= look_new ? '0 : pos_sel;
        end
        S_CALC: begin
          out_valid_r <= 1'b1;
          if (is_rec) begin
            if (full_r) begin
              out_idx_r <= '0;
              out_new_r <= 1'b0;
              out_cnt_r <= '0;
              out_tot_r <= '0;
            end else begin
              out_idx_r <= RDE_W'(e_r);
              out_new_r <= new_r;
              out_cnt_r <= cnt_nxt;
              out_tot_r <= tot_nxt;
            end
            out_full_r <= full_r;
            out_smp_r  <= '0;
            if (!full_r && new_r) begin
              entries_used_r <= entries_used_r + 1'b1;
            end
          end else begin
            out_idx_r  <= rde_r;
            out_new_r  <= 1'b0;
            out_full_r <= 1'b0;
            out_cnt_r  <= rd_ok_r ? stat_rdata[STAT_W-1:TOT_W] : '0;
            out_tot_r  <= rd_ok_r ? stat_rdata[TOT_W-1:0] : '0;
            out_smp_r  <= (rd_ok_r && age_ok_r) ? smp_rdata : '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_index = out_idx_r;
  assign out_ch.was_new     = out_new_r;
  assign out_ch.table_full  = out_full_r;
  assign out_ch.call_count  = out_cnt_r;
  assign out_ch.total_time  = out_tot_r;
  assign out_ch.sample_out  = out_smp_r;

  `ASSERT_CLK(a_used_matches_cells, clk, rst_n, $countones(cell_valid) == 32'(entries_used_r), "used count differs from taken cells")
  `ASSERT_CLK(a_cells_packed, clk, rst_n, (cell_valid & ~cell_prev) == '0, "taken cells are not contiguous from cell 0")
  `ASSERT_CLK(a_single_hit, clk, rst_n, $onehot0(hit_vec), "key matched more than one cell")
  `ASSERT_IMPLIES(a_full_result, clk, rst_n, out_valid_r && out_full_r, !out_new_r && out_cnt_r == '0 && out_tot_r == '0, "dropped sample reports nonzero statistics")

endmodule

// ----- design/ktst_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module ktst_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/ktst_cell.sv -----
// One table cell: allocation flag, key and ring position/fill of one entry.
// Depends on ktst_pkg; the allocation flag chains to the next cell.
`timescale 1ns / 1ps

module ktst_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ktst_pkg::cell_ctl_t        ctl,
  input  logic                       sel,
  input  logic                       prev_valid,
  input  logic [ktst_pkg::KEY_W-1:0] look_key,
  output ktst_pkg::cell_stat_t       stat
);
  import ktst_pkg::*;

  logic              valid_r;
  logic [KEY_W-1:0]  key_r;
  logic [POS_W-1:0]  pos_r;
  logic [FILL_W-1:0] fill_r;
  logic [POS_W-1:0]  pos_base, pos_nxt;
  logic [FILL_W-1:0] fill_base, fill_nxt;

  always_comb begin
    pos_base  = ctl.alloc ? '0 : pos_r;
    fill_base = ctl.alloc ? '0 : fill_r;
    pos_nxt   = (pos_base == POS_W'(HISTORY_DEPTH - 1)) ? '0 : pos_base + 1'b1;
    fill_nxt  = (fill_base == FILL_W'(HISTORY_DEPTH)) ? fill_base : fill_base + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.upd && sel && ctl.alloc) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd && sel) begin
      if (ctl.alloc) begin
        key_r <= ctl.key;
      end
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    stat.valid = valid_r;
    stat.hit   = valid_r && (key_r == look_key);
    // first free cell: neighbor below is taken, this one is not
    stat.free  = !valid_r && prev_valid;
    stat.pos   = pos_r;
    stat.fill  = fill_r;
  end

endmodule

// ----- tb/sv/ktst_stats_checker.sv -----
// Scoreboard for keyed_timing_stats_table: mirrors the entry table, the sample rings and
// the saturating statistics, and compares every result transaction field by field.
// Depends on ktst_pkg, ktst_in_if, ktst_out_if.
`timescale 1ns / 1ps

module ktst_stats_checker (
  input  logic        clk,
  input  logic        rst_n,
  ktst_in_if          cmd_mon,
  ktst_out_if         res_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned results_seen,
  output int unsigned allocs_seen,
  output int unsigned full_seen,
  output int unsigned saturated_seen
);
  import ktst_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [RDE_W-1:0]  entry_index;
    logic              was_new;
    logic              table_full;
    logic [CNT_W-1:0]  call_count;
    logic [TOT_W-1:0]  total_time;
    logic [TIME_W-1:0] sample_out;
  } stats_result_t;

  stats_result_t expected_stats[$];

  // mirrored table
  int unsigned       alloc_cnt;
  logic [KEY_W-1:0]  key_of[ENTRIES];
  logic [CNT_W-1:0]  count_of[ENTRIES];
  logic [TOT_W-1:0]  total_of[ENTRIES];
  logic [TIME_W-1:0] hist[ENTRIES][HISTORY_DEPTH];
  int unsigned       hist_wr[ENTRIES];
  int unsigned       hist_len[ENTRIES];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < MAX_PRINTED)
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic stats_result_t apply_command(input logic [CMD_W-1:0] op,
                                                  input logic [KEY_FW-1:0] key,
                                                  input logic [TIME_W-1:0] smp,
                                                  input logic [RDE_W-1:0] rd_entry,
                                                  input logic [AGE_W-1:0] rd_age);
    stats_result_t    r;
    logic [KEY_W-1:0] k;
    logic [TOT_W:0]   sum;
    int unsigned      e;
    int unsigned      slot;
    bit               hit;
    r   = '0;
    k   = key[KEY_W-1:0];
    e   = 0;
    hit = 1'b0;
    if (op == CMD_RECORD) begin
      for (int i = 0; i < alloc_cnt; i++) begin
        if (!hit && key_of[i] == k) begin
          e   = i;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (alloc_cnt >= ENTRIES) begin
          r.table_full = 1'b1;
        end else begin
          e = alloc_cnt;
          alloc_cnt++;
          key_of[e]   = k;
          count_of[e] = '0;
          total_of[e] = '0;
          hist_wr[e]  = 0;
          hist_len[e] = 0;
          r.was_new   = 1'b1;
        end
      end
      if (!r.table_full) begin
        sum = total_of[e] + smp;
        total_of[e] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
        if (count_of[e] != '1) count_of[e]++;
        hist[e][hist_wr[e]] = smp;
        hist_wr[e] = (hist_wr[e] + 1) % HISTORY_DEPTH;
        if (hist_len[e] < HISTORY_DEPTH) hist_len[e]++;
        r.entry_index = RDE_W'(e);
        r.call_count  = count_of[e];
        r.total_time  = total_of[e];
      end
    end else begin
      r.entry_index = rd_entry;
      if (rd_entry < alloc_cnt) begin
        r.call_count = count_of[rd_entry];
        r.total_time = total_of[rd_entry];
        if (rd_age < hist_len[rd_entry]) begin
          slot = (hist_wr[rd_entry] + HISTORY_DEPTH - 1 - rd_age) % HISTORY_DEPTH;
          r.sample_out = hist[rd_entry][slot];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    stats_result_t got;
    stats_result_t want;
    if (!rst_n) begin
      expected_stats.delete();
      alloc_cnt = 0;
      foreach (key_of[e]) begin
        key_of[e]   = '0;
        count_of[e] = '0;
        total_of[e] = '0;
        hist_wr[e]  = 0;
        hist_len[e] = 0;
      end
      foreach (hist[e, s]) hist[e][s] = '0;
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        expected_stats.push_back(apply_command(cmd_mon.cmd, cmd_mon.event_key,
                                               cmd_mon.sample_time, cmd_mon.read_entry,
                                               cmd_mon.read_age));
      if (res_mon.valid && res_mon.ready) begin
        got.entry_index = res_mon.entry_index;
        got.was_new     = res_mon.was_new;
        got.table_full  = res_mon.table_full;
        got.call_count  = res_mon.call_count;
        got.total_time  = res_mon.total_time;
        got.sample_out  = res_mon.sample_out;
        if (expected_stats.size() == 0) begin
          report_mismatch("result with nothing outstanding", got.entry_index, '0);
        end else begin
          want = expected_stats.pop_front();
          check_field("entry_index", got.entry_index, want.entry_index);
          check_field("was_new", got.was_new, want.was_new);
          check_field("table_full", got.table_full, want.table_full);
          check_field("call_count", got.call_count, want.call_count);
          check_field("total_time", got.total_time, want.total_time);
          check_field("sample_out", got.sample_out, want.sample_out);
          results_seen++;
          if (want.was_new) allocs_seen++;
          if (want.table_full) full_seen++;
          if (want.total_time == '1) saturated_seen++;
        end
      end
    end
    pending = expected_stats.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the keyed_timing_stats_table bench: clock, reset, command stimulus, result drain,
// stall watchdog and verdict. Depends on ktst_pkg, both channel interfaces,
// the block itself and ktst_stats_checker.
`timescale 1ns / 1ps

module testbench;
  import ktst_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD_CYC = 90;
  localparam int RANDOM_A      = 500;
  localparam int RANDOM_B      = 500;
  localparam int QUIET_TAIL    = 150;
  localparam int SOAK_RECORDS  = 70;   // enough to wrap one sample ring
  localparam int DRAIN_CYC     = 8;

  logic clk;
  logic rst_n;

  ktst_in_if  cmd_ch ();
  ktst_out_if res_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned allocs_seen;
  int unsigned full_seen;
  int unsigned saturated_seen;

  keyed_timing_stats_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  ktst_stats_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_mon        (cmd_ch),
    .res_mon        (res_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .allocs_seen    (allocs_seen),
    .full_seen      (full_seen),
    .saturated_seen (saturated_seen)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  bit          idle_on   = 1'b1;
  bit          hold_long = 1'b0;
  int unsigned sent_cnt  = 0;
  int unsigned quiet_cycles = 0;

  // allocation order and ring occupancy as seen by the stimulus, so that reads only
  // touch allocated entries and written ring slots
  logic [KEY_W-1:0] seen_keys[$];
  int unsigned      seen_fill[ENTRIES];

  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [KEY_FW-1:0] key,
                          input logic [TIME_W-1:0] smp, input logic [RDE_W-1:0] ent,
                          input logic [AGE_W-1:0] age);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.cmd         <= op;
    cmd_ch.event_key   <= key;
    cmd_ch.sample_time <= smp;
    cmd_ch.read_entry  <= ent;
    cmd_ch.read_age    <= age;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic record_sample(input logic [KEY_FW-1:0] key, input logic [TIME_W-1:0] smp);
    int slot;
    slot = -1;
    foreach (seen_keys[i])
      if (slot < 0 && seen_keys[i] == key[KEY_W-1:0]) slot = i;
    if (slot < 0 && seen_keys.size() < ENTRIES) begin
      seen_keys.push_back(key[KEY_W-1:0]);
      slot = seen_keys.size() - 1;
    end
    if (slot >= 0 && seen_fill[slot] < HISTORY_DEPTH) seen_fill[slot]++;
    send_cmd(CMD_RECORD, key, smp, RDE_W'($urandom), AGE_W'($urandom));
  endtask

  task automatic read_stats(input int unsigned ent, input int unsigned age);
    send_cmd(CMD_READ, KEY_FW'($urandom), TIME_W'($urandom), ent[RDE_W-1:0],
             age[AGE_W-1:0]);
  endtask

  task automatic random_item();
    int unsigned       pick;
    int unsigned       ent;
    int unsigned       hot;
    logic [KEY_FW-1:0] key;
    logic [TIME_W-1:0] smp;
    pick = $urandom_range(0, 99);
    if (seen_keys.size() == 0 || pick < 55) begin
      hot  = (seen_keys.size() < 4) ? seen_keys.size() : 4;
      pick = $urandom_range(0, 99);
      if (pick < 40 && hot > 0)
        key = seen_keys[$urandom_range(0, hot - 1)];
      else if (pick < 72 && seen_keys.size() > 0)
        key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
      else
        key = KEY_FW'($urandom);   // mostly fresh keys: allocate or hit a full table
      case ($urandom_range(0, 9))
        0:       smp = '0;
        1:       smp = '1;
        2:       smp = TIME_W'($urandom_range(0, 65535));
        default: smp = $urandom;
      endcase
      record_sample(key, smp);
    end else begin
      ent  = $urandom_range(0, seen_keys.size() - 1);
      pick = $urandom_range(0, 99);
      if (pick < 30)
        read_stats(ent, 0);
      else if (pick < 50)
        read_stats(ent, seen_fill[ent] - 1);
      else
        read_stats(ent, $urandom_range(0, seen_fill[ent] - 1));
    end
  endtask

  // result side back-pressure
  initial begin : result_drain
    res_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYC - 1) @(negedge clk);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  // ends the run when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CMD_RECORD;
    cmd_ch.event_key   = '0;
    cmd_ch.sample_time = '0;
    cmd_ch.read_entry  = '0;
    cmd_ch.read_age    = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: key and sample extremes, hits, allocations, oldest and newest ring reads
    record_sample(16'h0000, 32'h0000_0000);
    record_sample(16'hFFFF, 32'hFFFF_FFFF);
    record_sample(16'h0000, 32'hFFFF_FFFF);
    record_sample(16'h0000, 32'h0001_0000);
    read_stats(0, 0);
    read_stats(0, 2);
    read_stats(1, 0);
    record_sample(16'h5A5A, 32'hA5A5_A5A5);
    record_sample(16'hA5A5, 32'h5A5A_5A5A);
    read_stats(2, 0);
    read_stats(3, 0);
    record_sample(16'hFFFF, 32'h0000_0001);
    read_stats(1, 1);
    read_stats(1, 0);

    for (int i = 0; i < RANDOM_A; i++) begin
      if (i == 150) hold_long = 1'b1;   // back up the pipeline into the command side
      random_item();
    end

    // wrap entry 1's sample ring with back-to-back max samples
    idle_on = 1'b0;
    for (int i = 0; i < SOAK_RECORDS; i++) record_sample(16'hFFFF, 32'hFFFF_FFFF);
    read_stats(1, 0);
    read_stats(1, HISTORY_DEPTH - 1);
    idle_on = 1'b1;

    for (int i = 0; i < RANDOM_B; i++) begin
      if (i == 300) hold_long = 1'b1;
      random_item();
    end

    idle_on = 1'b0;
    for (int i = 0; i < QUIET_TAIL; i++) random_item();
    cmd_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d commands; %0d results checked, %0d entries allocated,",
             sent_cnt, results_seen, allocs_seen);
    $display("%0d samples dropped on a full table, %0d results carried a saturated total.",
             full_seen, saturated_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
